// ----- rtl/ttkm_pkg.sv -----
// ttkm_pkg: shared types, codes and defaults for the tournament-tree k-way merge.
// Used by every file of the block but ttkm_chan_if; depends on nothing.

package ttkm_pkg;

    // Default sizing, handed to the top level parameters
    localparam int NUM_LISTS_DEF  = 8;
    localparam int LIST_DEPTH_DEF = 16;
    localparam int VALUE_BITS_DEF = 31;

    // Fixed widths of the channel words
    localparam int LIST_INDEX_W = 3;
    localparam int VALUE_W      = 31;

    // Depth of the queue between the front and back ends
    localparam int QUEUE_DEPTH  = 2;

    // Command codes on the input word
    localparam logic CMD_APPEND  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        STATUS_APPENDED  = 2'd0,
        STATUS_DROPPED   = 2'd1,
        STATUS_EXTRACTED = 2'd2,
        STATUS_EMPTY     = 2'd3
    } status_t;

    // Operation classified by the front end
    typedef enum logic [1:0] {
        OP_APPEND,
        OP_DROP,
        OP_EXTRACT
    } op_t;

    // Back end sequencer
    typedef enum logic {
        BK_IDLE,
        BK_LOAD
    } back_state_t;

    typedef struct packed {
        logic                    cmd;
        logic [LIST_INDEX_W-1:0] list_index;
        logic [VALUE_W-1:0]      value;
    } in_word_t;

    typedef struct packed {
        status_t                 status;
        logic [VALUE_W-1:0]      min_value;
        logic [LIST_INDEX_W-1:0] source_list;
    } out_word_t;

endpackage

// ----- rtl/ttkm_chan_if.sv -----
// ttkm_chan_if: valid/ready channel carrying one word of a chosen payload type.
// Payload types come from ttkm_pkg.

interface ttkm_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/ttkm_front.sv -----
// ttkm_front: accepts input words, classifies them and holds them in a short queue.
// Depends on ttkm_pkg and ttkm_chan_if.

module ttkm_front #(
    parameter int NUM_LISTS  = ttkm_pkg::NUM_LISTS_DEF,
    parameter int VALUE_BITS = ttkm_pkg::VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    ttkm_chan_if.sink                    in_ch,
    output logic                         q_valid,
    input  logic                         q_ready,
    output ttkm_pkg::op_t                q_op,
    output logic [$clog2(NUM_LISTS)-1:0] q_list,
    output logic [VALUE_BITS-1:0]        q_value
);

    localparam int LIST_W = $clog2(NUM_LISTS);
    localparam int QPTR_W = (ttkm_pkg::QUEUE_DEPTH > 1) ? $clog2(ttkm_pkg::QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(ttkm_pkg::QUEUE_DEPTH + 1);

    ttkm_pkg::op_t         op_mem   [ttkm_pkg::QUEUE_DEPTH];
    logic [LIST_W-1:0]     list_mem [ttkm_pkg::QUEUE_DEPTH];
    logic [VALUE_BITS-1:0] value_mem[ttkm_pkg::QUEUE_DEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    logic          push;
    logic          pop;
    ttkm_pkg::op_t in_op;

    // Classify: an append with an out-of-range list index is queued as a drop
    always_comb
    begin
        if (in_ch.payload.cmd == ttkm_pkg::CMD_EXTRACT)
        begin
            in_op = ttkm_pkg::OP_EXTRACT;
        end
        else if (32'(in_ch.payload.list_index) >= 32'(NUM_LISTS))
        begin
            in_op = ttkm_pkg::OP_DROP;
        end
        else
        begin
            in_op = ttkm_pkg::OP_APPEND;
        end
    end

    // Queue handshakes
    assign in_ch.ready = (count_reg != QCNT_W'(ttkm_pkg::QUEUE_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (count_reg != '0);
    assign pop         = q_valid && q_ready;

    assign q_op    = op_mem[rd_ptr_reg];
    assign q_list  = list_mem[rd_ptr_reg];
    assign q_value = value_mem[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(ttkm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(ttkm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage, payload only
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_mem[wr_ptr_reg]    <= in_op;
            list_mem[wr_ptr_reg]  <= LIST_W'(in_ch.payload.list_index);
            value_mem[wr_ptr_reg] <= VALUE_BITS'(in_ch.payload.value);
        end
    end

endmodule

// ----- rtl/ttkm_tree.sv -----
// ttkm_tree: registered tournament tree of minimum winners over the list heads.
// One register level per tree level; ties go to the left (lower) list. Depends on ttkm_pkg.

module ttkm_tree #(
    parameter int NUM_LISTS  = ttkm_pkg::NUM_LISTS_DEF,
    parameter int VALUE_BITS = ttkm_pkg::VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         leaf_vld [NUM_LISTS],
    input  logic [VALUE_BITS-1:0]        leaf_val [NUM_LISTS],
    output logic                         root_vld,
    output logic [$clog2(NUM_LISTS)-1:0] root_idx,
    output logic [VALUE_BITS-1:0]        root_val
);

    localparam int LIST_W  = $clog2(NUM_LISTS);
    localparam int NUM_PAD = 1 << LIST_W;

    logic                  pad_vld [NUM_PAD];
    logic [VALUE_BITS-1:0] pad_val [NUM_PAD];

    logic                  node_vld_reg [1:NUM_PAD-1];
    logic [LIST_W-1:0]     node_idx_reg [1:NUM_PAD-1];
    logic [VALUE_BITS-1:0] node_val_reg [1:NUM_PAD-1];

    // Leaves padded to a power of two; padding is always empty
    for (genvar gi = 0; gi < NUM_PAD; gi++)
    begin : g_leaf
        if (gi < NUM_LISTS)
        begin : g_real
            assign pad_vld[gi] = leaf_vld[gi];
            assign pad_val[gi] = leaf_val[gi];
        end
        else
        begin : g_pad
            assign pad_vld[gi] = 1'b0;
            assign pad_val[gi] = '0;
        end
    end

    // Internal nodes, heap order, node 1 is the root
    for (genvar gn = 1; gn < NUM_PAD; gn++)
    begin : g_node
        logic                  lft_vld;
        logic                  rgt_vld;
        logic [LIST_W-1:0]     lft_idx;
        logic [LIST_W-1:0]     rgt_idx;
        logic [VALUE_BITS-1:0] lft_val;
        logic [VALUE_BITS-1:0] rgt_val;
        logic                  lft_wins;

        if (2 * gn >= NUM_PAD)
        begin : g_from_leaf
            assign lft_vld = pad_vld[2*gn - NUM_PAD];
            assign rgt_vld = pad_vld[2*gn + 1 - NUM_PAD];
            assign lft_idx = LIST_W'(2*gn - NUM_PAD);
            assign rgt_idx = LIST_W'(2*gn + 1 - NUM_PAD);
            assign lft_val = pad_val[2*gn - NUM_PAD];
            assign rgt_val = pad_val[2*gn + 1 - NUM_PAD];
        end
        else
        begin : g_from_node
            assign lft_vld = node_vld_reg[2*gn];
            assign rgt_vld = node_vld_reg[2*gn + 1];
            assign lft_idx = node_idx_reg[2*gn];
            assign rgt_idx = node_idx_reg[2*gn + 1];
            assign lft_val = node_val_reg[2*gn];
            assign rgt_val = node_val_reg[2*gn + 1];
        end

        // Left keeps the match on a tie
        assign lft_wins = lft_vld && (!rgt_vld || (lft_val <= rgt_val));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                node_vld_reg[gn] <= 1'b0;
            end
            else
            begin
                node_vld_reg[gn] <= lft_vld || rgt_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            node_idx_reg[gn] <= lft_wins ? lft_idx : rgt_idx;
            node_val_reg[gn] <= lft_wins ? lft_val : rgt_val;
        end
    end

    assign root_vld = node_vld_reg[1];
    assign root_idx = node_idx_reg[1];
    assign root_val = node_val_reg[1];

endmodule

// ----- rtl/ttkm_back.sv -----
// ttkm_back: executes queued operations on the list store and list pointers, feeds the list
// heads to the tree and registers the result word. Depends on ttkm_pkg and ttkm_chan_if.

module ttkm_back #(
    parameter int NUM_LISTS  = ttkm_pkg::NUM_LISTS_DEF,
    parameter int LIST_DEPTH = ttkm_pkg::LIST_DEPTH_DEF,
    parameter int VALUE_BITS = ttkm_pkg::VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  ttkm_pkg::op_t                q_op,
    input  logic [$clog2(NUM_LISTS)-1:0] q_list,
    input  logic [VALUE_BITS-1:0]        q_value,
    input  logic                         root_vld,
    input  logic [$clog2(NUM_LISTS)-1:0] root_idx,
    input  logic [VALUE_BITS-1:0]        root_val,
    output logic                         leaf_vld [NUM_LISTS],
    output logic [VALUE_BITS-1:0]        leaf_val [NUM_LISTS],
    ttkm_chan_if.source                  out_ch
);

    localparam int LIST_W    = $clog2(NUM_LISTS);
    localparam int PTR_W     = $clog2(LIST_DEPTH);
    localparam int CNT_W     = $clog2(LIST_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_LISTS * LIST_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int LEVELS    = LIST_W;
    localparam int SETTLE_W  = $clog2(LEVELS + 1);

    ttkm_pkg::back_state_t state_reg, state_next;

    logic [CNT_W-1:0]      fill_reg [NUM_LISTS];
    logic [PTR_W-1:0]      head_reg [NUM_LISTS];
    logic [PTR_W-1:0]      tail_reg [NUM_LISTS];
    logic [VALUE_BITS-1:0] leaf_val_reg [NUM_LISTS];
    logic [LIST_W-1:0]     pop_list_reg;
    logic [SETTLE_W-1:0]   settle_reg;
    logic [VALUE_BITS-1:0] list_mem [MEM_DEPTH];
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic                  out_valid_reg;
    ttkm_pkg::out_word_t   out_word_reg;

    logic                  slot_free;
    logic                  is_extract;
    logic                  take;
    logic [LIST_W-1:0]     cur_list;
    logic [CNT_W-1:0]      cur_fill;
    logic [PTR_W-1:0]      cur_head;
    logic [PTR_W-1:0]      cur_tail;
    logic                  list_full;
    logic [PTR_W-1:0]      head_adv;
    logic [PTR_W-1:0]      tail_adv;
    logic [ADDR_W-1:0]     base_addr;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  do_append;
    logic                  do_pop;
    logic                  leaf_from_in;
    logic                  leaf_from_mem;
    ttkm_pkg::out_word_t   res_word;

    // List selected for this word: the winner on extract, the target on append
    assign is_extract = (q_op == ttkm_pkg::OP_EXTRACT);
    assign slot_free  = !out_valid_reg || out_ch.ready;
    assign cur_list   = is_extract ? root_idx : q_list;
    assign cur_fill   = fill_reg[cur_list];
    assign cur_head   = head_reg[cur_list];
    assign cur_tail   = tail_reg[cur_list];
    assign list_full  = (cur_fill == CNT_W'(LIST_DEPTH));
    assign head_adv   = (cur_head == PTR_W'(LIST_DEPTH - 1)) ? '0 : cur_head + 1'b1;
    assign tail_adv   = (cur_tail == PTR_W'(LIST_DEPTH - 1)) ? '0 : cur_tail + 1'b1;
    assign base_addr  = ADDR_W'(cur_list) * ADDR_W'(LIST_DEPTH);
    assign wr_addr    = base_addr + ADDR_W'(cur_tail);
    assign rd_addr    = base_addr + ADDR_W'(head_adv);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ttkm_pkg::BK_IDLE:
            begin
                if (take && is_extract && root_vld)
                begin
                    state_next = ttkm_pkg::BK_LOAD;
                end
            end
            ttkm_pkg::BK_LOAD:
            begin
                state_next = ttkm_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = ttkm_pkg::BK_IDLE;
            end
        endcase
    end

    // Sequencer outputs; an extract waits for the tree to settle
    always_comb
    begin
        q_ready       = 1'b0;
        leaf_from_mem = 1'b0;
        unique case (state_reg)
            ttkm_pkg::BK_IDLE:
            begin
                q_ready = slot_free && (!is_extract || (settle_reg == '0));
            end
            ttkm_pkg::BK_LOAD:
            begin
                leaf_from_mem = 1'b1;
            end
            default:
            begin
                q_ready = 1'b0;
            end
        endcase
    end

    assign take         = q_valid && q_ready;
    assign do_append    = take && (q_op == ttkm_pkg::OP_APPEND) && !list_full;
    assign do_pop       = take && is_extract && root_vld;
    assign leaf_from_in = do_append && (cur_fill == '0);

    // Result word
    always_comb
    begin
        res_word = '0;
        case (q_op)
            ttkm_pkg::OP_APPEND:
            begin
                res_word.status = list_full ? ttkm_pkg::STATUS_DROPPED
                                            : ttkm_pkg::STATUS_APPENDED;
            end
            ttkm_pkg::OP_EXTRACT:
            begin
                if (root_vld)
                begin
                    res_word.status      = ttkm_pkg::STATUS_EXTRACTED;
                    res_word.min_value   = ttkm_pkg::VALUE_W'(root_val);
                    res_word.source_list = ttkm_pkg::LIST_INDEX_W'(root_idx);
                end
                else
                begin
                    res_word.status = ttkm_pkg::STATUS_EMPTY;
                end
            end
            default:
            begin
                res_word.status = ttkm_pkg::STATUS_DROPPED;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ttkm_pkg::BK_IDLE;
            settle_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                fill_reg[i] <= '0;
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (do_append)
            begin
                tail_reg[cur_list] <= tail_adv;
                fill_reg[cur_list] <= cur_fill + 1'b1;
            end
            if (do_pop)
            begin
                head_reg[cur_list] <= head_adv;
                fill_reg[cur_list] <= cur_fill - 1'b1;
            end
            // A changed leaf passes every register level of the tree before it reaches the root
            if (leaf_from_in || leaf_from_mem)
            begin
                settle_reg <= SETTLE_W'(LEVELS);
            end
            else if (settle_reg != '0)
            begin
                settle_reg <= settle_reg - 1'b1;
            end
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result and pop bookkeeping, payload only
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_word_reg <= res_word;
        end
        if (do_pop)
        begin
            pop_list_reg <= cur_list;
        end
    end

    // List store: one write port, one registered read port (next head on pop)
    always_ff @(posedge clk)
    begin
        if (do_append)
        begin
            list_mem[wr_addr] <= q_value;
        end
        rd_data_reg <= list_mem[rd_addr];
    end

    // Head copies seen by the tree
    always_ff @(posedge clk)
    begin
        if (leaf_from_in)
        begin
            leaf_val_reg[cur_list] <= q_value;
        end
        else if (leaf_from_mem)
        begin
            leaf_val_reg[pop_list_reg] <= rd_data_reg;
        end
    end

    for (genvar gi = 0; gi < NUM_LISTS; gi++)
    begin : g_leaf_out
        assign leaf_vld[gi] = (fill_reg[gi] != '0);
        assign leaf_val[gi] = leaf_val_reg[gi];
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_word_reg;

endmodule

// ----- rtl/tournament_tree_kway_merge_top.sv -----
// Tournament-tree k-way merge. Each word is registered in the input queue first. Append and
// drop words give their result word in the cycle after the queue hands them over. An extract
// that finds a head runs in order through the winner and the store read, the load of the new
// head, then the settle of the winner path through each tree level. An append into an empty
// list holds the next extract back until the winner path has settled. Reset empties all lists
// and marks every tree node empty; the store is not cleared.

module tournament_tree_kway_merge_top #(
    parameter int NUM_LISTS  = ttkm_pkg::NUM_LISTS_DEF,
    parameter int LIST_DEPTH = ttkm_pkg::LIST_DEPTH_DEF,
    parameter int VALUE_BITS = ttkm_pkg::VALUE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ttkm_chan_if.sink   in_ch,
    ttkm_chan_if.source out_ch
);

    localparam int LIST_W = $clog2(NUM_LISTS);

    logic                  q_valid;
    logic                  q_ready;
    ttkm_pkg::op_t         q_op;
    logic [LIST_W-1:0]     q_list;
    logic [VALUE_BITS-1:0] q_value;
    logic                  root_vld;
    logic [LIST_W-1:0]     root_idx;
    logic [VALUE_BITS-1:0] root_val;
    logic                  leaf_vld [NUM_LISTS];
    logic [VALUE_BITS-1:0] leaf_val [NUM_LISTS];

    // Front end: accept, classify, queue
    ttkm_front #(
        .NUM_LISTS  (NUM_LISTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_op    (q_op),
        .q_list  (q_list),
        .q_value (q_value)
    );

    // Winner tree over the list heads
    ttkm_tree #(
        .NUM_LISTS  (NUM_LISTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_tree (
        .clk      (clk),
        .rst_n    (rst_n),
        .leaf_vld (leaf_vld),
        .leaf_val (leaf_val),
        .root_vld (root_vld),
        .root_idx (root_idx),
        .root_val (root_val)
    );

    // Back end: lists, store and result register
    ttkm_back #(
        .NUM_LISTS  (NUM_LISTS),
        .LIST_DEPTH (LIST_DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_op     (q_op),
        .q_list   (q_list),
        .q_value  (q_value),
        .root_vld (root_vld),
        .root_idx (root_idx),
        .root_val (root_val),
        .leaf_vld (leaf_vld),
        .leaf_val (leaf_val),
        .out_ch   (out_ch)
    );

`ifndef SYNTHESIS
    // Only an extracted word carries a value and a source list
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && (out_ch.payload.status != ttkm_pkg::STATUS_EXTRACTED)
        |-> (out_ch.payload.min_value == '0) && (out_ch.payload.source_list == '0))
        else $error("non-extract result word carries value or source list");

    // An accepted word is queued at the next edge
    a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> q_valid)
        else $error("accepted word missing from the queue");

    // Every word taken by the back end gives a registered result word
    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && q_ready |=> out_ch.valid)
        else $error("queued word taken without a result word");
`endif

endmodule
